/* src/bfpa_pkg.sv */
// Shared types and constants of the best-fit pool allocator.
package bfpa_pkg;

  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned SPLIT_SLACK  = 100;
  localparam int unsigned MAX_BLOCKS   = 128;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned WIDE_W = ADDR_W + 2;
  localparam int unsigned TAG2   = 2 * HEADER_BYTES;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED = 2'd2;

  // Link: msb set means "none".
  typedef logic [LINK_W-1:0] link_t;
  localparam link_t LINK_NIL = {1'b1, {IDX_W{1'b0}}};

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              alloc;
    link_t             nxt;
    link_t             prv;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  localparam rec_t REC_RESET = '{
    start: '0,
    size:  ADDR_W'(POOL_BYTES - TAG2),
    alloc: 1'b0,
    nxt:   LINK_NIL,
    prv:   LINK_NIL
  };

endpackage

/* src/bfpa_if.sv */
// Request and response channel interfaces.
interface bfpa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [bfpa_pkg::ADDR_W-1:0]   request_size;
  logic [bfpa_pkg::ADDR_W-1:0]   block_address;
  modport source(output valid, kind, request_size, block_address, input ready);
  modport sink(input valid, kind, request_size, block_address, output ready);
endinterface

interface bfpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfpa_pkg::ADDR_W-1:0]   payload_offset;
  logic [bfpa_pkg::STAT_W-1:0]   status;
  modport source(output valid, payload_offset, status, input ready);
  modport sink(input valid, payload_offset, status, output ready);
endinterface

/* src/bfpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module bfpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* src/best_fit_pool_allocator_unit.sv */
// Best-fit pool allocator: block table in one RAM, free-list walk and merge sequencer.
//
// Channels: req_i carries one request per beat (kind 0 allocate request_size bytes,
// kind 1 free the block at block_address). rsp_o returns exactly one beat per
// request: payload_offset (nonzero only for a successful allocation) and status
// (ok, no fit, already free or unknown address).
// All block records (start, size, allocated flag, free-list links) sit in one
// 128-entry RAM with registered read; valid flags and the free-list
// head/tail are flip-flops. One request is in work at a time.
// Sequencing: an allocate walks the free list at one RAM read per cycle. A free scans
// the table up to three times (own block, next neighbor, previous neighbor) at one
// entry per cycle; unlink and append steps on the free list follow as needed.
// Reset: the pool is one free block of the whole pool minus two tags, entry 0,
// which is served from a constant until first written; no clearing pass needed.
// Stall: the result waits in the output register; a new request is taken while it
// waits, but that request cannot complete until the previous beat has left.
module best_fit_pool_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfpa_req_if.sink    req_i,
  bfpa_rsp_if.source  rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_A_WALK, S_A_FOUND, S_A_MARK,
    S_F_SCAN, S_F_CHK, S_F_NB, S_F_PV0, S_F_PV,
    S_RM0, S_RM1, S_AP0, S_AP1, S_LK_RD, S_LK_WR, S_DONE
  } state_e;

  typedef enum logic {LK_NEXT, LK_PREV} lk_sel_e;

  localparam logic [bfpa_pkg::IDX_W-1:0] IDX_LAST = bfpa_pkg::IDX_W'(bfpa_pkg::MAX_BLOCKS - 1);

  state_e state_q, state_d, rm_ret_q, rm_ret_d, lk_ret_q, lk_ret_d;
  lk_sel_e lk_sel_q, lk_sel_d;

  logic [bfpa_pkg::MAX_BLOCKS-1:0] valid_q, valid_d;
  bfpa_pkg::link_t head_q, head_d, tail_q, tail_d;
  bfpa_pkg::link_t rm_p_q, rm_p_d, rm_n_q, rm_n_d;
  bfpa_pkg::link_t lk_tgt_q, lk_tgt_d, lk_val_q, lk_val_d;
  bfpa_pkg::link_t best_q, best_d;
  bfpa_pkg::rec_t best_rec_q, best_rec_d, cur_rec_q, cur_rec_d, app_rec_q, app_rec_d;
  logic [bfpa_pkg::IDX_W-1:0] ix_q, ix_d, cur_q, cur_d, app_idx_q, app_idx_d;
  logic [bfpa_pkg::ADDR_W-1:0] req_q, req_d, addr_q, addr_d;
  logic [bfpa_pkg::WIDE_W-1:0] tgt_q, tgt_d;
  logic [bfpa_pkg::ADDR_W-1:0] res_off_q, res_off_d, out_off_q, out_off_d;
  logic [bfpa_pkg::STAT_W-1:0] res_st_q, res_st_d, out_st_q, out_st_d;
  logic out_valid_q, out_valid_d;
  logic e0_init_q, e0_init_d;
  logic [bfpa_pkg::IDX_W-1:0] rd_addr_q, rd_addr_d;

  // RAM port
  logic re, we;
  logic [bfpa_pkg::IDX_W-1:0] raddr, waddr;
  bfpa_pkg::rec_t wdata, rd_raw, rd_rec;

  bfpa_ram #(.WIDTH(bfpa_pkg::REC_W), .DEPTH(bfpa_pkg::MAX_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  // Entry 0 reads as its reset record until first written.
  assign rd_rec = (e0_init_q && rd_addr_q == '0) ? bfpa_pkg::REC_RESET : rd_raw;

  // First unused table entry for a split remainder.
  logic [bfpa_pkg::IDX_W-1:0] spare;
  logic spare_ok;
  always_comb begin
    spare    = '0;
    spare_ok = 1'b0;
    for (int i = bfpa_pkg::MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        spare    = bfpa_pkg::IDX_W'(i);
        spare_ok = 1'b1;
      end
    end
  end

  logic fits, split, in_acc, out_acc;
  logic [bfpa_pkg::WIDE_W-1:0] end_wide;
  assign in_acc  = req_i.valid && req_i.ready;
  assign out_acc = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.payload_offset = out_off_q;
  assign rsp_o.status = out_st_q;

  assign end_wide = bfpa_pkg::WIDE_W'(rd_rec.start) + bfpa_pkg::WIDE_W'(rd_rec.size)
                  + bfpa_pkg::WIDE_W'(bfpa_pkg::TAG2);
  assign fits = (rd_rec.size >= req_q)
             && (best_q[bfpa_pkg::IDX_W] || rd_rec.size < best_rec_q.size);
  assign split = (bfpa_pkg::WIDE_W'(best_rec_q.size) >
                  bfpa_pkg::WIDE_W'(req_q) + bfpa_pkg::WIDE_W'(bfpa_pkg::SPLIT_SLACK))
              && (bfpa_pkg::WIDE_W'(best_rec_q.size) >
                  bfpa_pkg::WIDE_W'(req_q) + bfpa_pkg::WIDE_W'(bfpa_pkg::TAG2))
              && spare_ok;

  always_comb begin
    bfpa_pkg::rec_t r;
    r           = rd_rec;
    state_d     = state_q;
    rm_ret_d    = rm_ret_q;
    lk_ret_d    = lk_ret_q;
    lk_sel_d    = lk_sel_q;
    valid_d     = valid_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rm_p_d      = rm_p_q;
    rm_n_d      = rm_n_q;
    lk_tgt_d    = lk_tgt_q;
    lk_val_d    = lk_val_q;
    best_d      = best_q;
    best_rec_d  = best_rec_q;
    cur_rec_d   = cur_rec_q;
    app_rec_d   = app_rec_q;
    ix_d        = ix_q;
    cur_d       = cur_q;
    app_idx_d   = app_idx_q;
    req_d       = req_q;
    addr_d      = addr_q;
    tgt_d       = tgt_q;
    res_off_d   = res_off_q;
    res_st_d    = res_st_q;
    out_off_d   = out_off_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && !out_acc;
    re          = 1'b0;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rd_rec;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d     = req_i.request_size;
          addr_d    = req_i.block_address;
          res_off_d = '0;
          best_d    = bfpa_pkg::LINK_NIL;
          if (req_i.kind == bfpa_pkg::KIND_ALLOC) begin
            if (head_q[bfpa_pkg::IDX_W]) begin
              res_st_d = bfpa_pkg::ST_NOFIT;
              state_d  = S_DONE;
            end else begin
              re      = 1'b1;
              raddr   = head_q[bfpa_pkg::IDX_W-1:0];
              state_d = S_A_WALK;
            end
          end else begin
            re      = 1'b1;
            raddr   = '0;
            ix_d    = '0;
            state_d = S_F_SCAN;
          end
        end
      end
      S_A_WALK: begin
        if (fits) begin
          best_d     = {1'b0, rd_addr_q};
          best_rec_d = rd_rec;
        end
        if (rd_rec.nxt[bfpa_pkg::IDX_W]) begin
          state_d = S_A_FOUND;
        end else begin
          re    = 1'b1;
          raddr = rd_rec.nxt[bfpa_pkg::IDX_W-1:0];
        end
      end
      S_A_FOUND: begin
        if (best_q[bfpa_pkg::IDX_W]) begin
          res_st_d = bfpa_pkg::ST_NOFIT;
          state_d  = S_DONE;
        end else begin
          rm_p_d   = best_rec_q.prv;
          rm_n_d   = best_rec_q.nxt;
          rm_ret_d = S_A_MARK;
          state_d  = S_RM0;
        end
      end
      S_A_MARK: begin
        we        = 1'b1;
        waddr     = best_q[bfpa_pkg::IDX_W-1:0];
        wdata     = best_rec_q;
        wdata.alloc = 1'b1;
        wdata.nxt = bfpa_pkg::LINK_NIL;
        wdata.prv = bfpa_pkg::LINK_NIL;
        res_st_d  = bfpa_pkg::ST_OK;
        res_off_d = best_rec_q.start + bfpa_pkg::ADDR_W'(bfpa_pkg::HEADER_BYTES);
        if (split) begin
          wdata.size      = req_q;
          valid_d[spare]  = 1'b1;
          app_idx_d       = spare;
          app_rec_d.start = best_rec_q.start + bfpa_pkg::ADDR_W'(bfpa_pkg::TAG2) + req_q;
          app_rec_d.size  = best_rec_q.size - req_q - bfpa_pkg::ADDR_W'(bfpa_pkg::TAG2);
          app_rec_d.alloc = 1'b0;
          app_rec_d.nxt   = bfpa_pkg::LINK_NIL;
          app_rec_d.prv   = bfpa_pkg::LINK_NIL;
          state_d         = S_AP0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_SCAN: begin
        if (valid_q[ix_q] &&
            rd_rec.start + bfpa_pkg::ADDR_W'(bfpa_pkg::HEADER_BYTES) == addr_q) begin
          cur_d     = ix_q;
          cur_rec_d = rd_rec;
          state_d   = S_F_CHK;
        end else if (ix_q == IDX_LAST) begin
          res_st_d = bfpa_pkg::ST_FREED;
          state_d  = S_DONE;
        end else begin
          ix_d  = ix_q + 1'b1;
          re    = 1'b1;
          raddr = ix_q + 1'b1;
        end
      end
      S_F_CHK: begin
        if (!cur_rec_q.alloc) begin
          res_st_d = bfpa_pkg::ST_FREED;
          state_d  = S_DONE;
        end else begin
          cur_rec_d.alloc = 1'b0;
          res_st_d = bfpa_pkg::ST_OK;
          tgt_d    = bfpa_pkg::WIDE_W'(cur_rec_q.start) + bfpa_pkg::WIDE_W'(cur_rec_q.size)
                   + bfpa_pkg::WIDE_W'(bfpa_pkg::TAG2);
          ix_d     = '0;
          re       = 1'b1;
          raddr    = '0;
          state_d  = S_F_NB;
        end
      end
      S_F_NB: begin
        if (valid_q[ix_q] && bfpa_pkg::WIDE_W'(rd_rec.start) == tgt_q) begin
          if (!rd_rec.alloc) begin
            cur_rec_d.size = cur_rec_q.size + rd_rec.size + bfpa_pkg::ADDR_W'(bfpa_pkg::TAG2);
            valid_d[ix_q]  = 1'b0;
            rm_p_d   = rd_rec.prv;
            rm_n_d   = rd_rec.nxt;
            rm_ret_d = S_F_PV0;
            state_d  = S_RM0;
          end else begin
            state_d = S_F_PV0;
          end
        end else if (ix_q == IDX_LAST) begin
          state_d = S_F_PV0;
        end else begin
          ix_d  = ix_q + 1'b1;
          re    = 1'b1;
          raddr = ix_q + 1'b1;
        end
      end
      S_F_PV0: begin
        ix_d    = '0;
        re      = 1'b1;
        raddr   = '0;
        state_d = S_F_PV;
      end
      S_F_PV: begin
        if (valid_q[ix_q] && ix_q != cur_q && !rd_rec.alloc &&
            end_wide == bfpa_pkg::WIDE_W'(cur_rec_q.start)) begin
          app_idx_d      = ix_q;
          app_rec_d      = rd_rec;
          app_rec_d.size = rd_rec.size + cur_rec_q.size + bfpa_pkg::ADDR_W'(bfpa_pkg::TAG2);
          valid_d[cur_q] = 1'b0;
          rm_p_d   = rd_rec.prv;
          rm_n_d   = rd_rec.nxt;
          rm_ret_d = S_AP0;
          state_d  = S_RM0;
        end else if (ix_q == IDX_LAST) begin
          app_idx_d = cur_q;
          app_rec_d = cur_rec_q;
          state_d   = S_AP0;
        end else begin
          ix_d  = ix_q + 1'b1;
          re    = 1'b1;
          raddr = ix_q + 1'b1;
        end
      end
      // Unlink: predecessor's next, then successor's prev (or head/tail).
      S_RM0: begin
        if (!rm_p_q[bfpa_pkg::IDX_W]) begin
          lk_tgt_d = rm_p_q;
          lk_sel_d = LK_NEXT;
          lk_val_d = rm_n_q;
          lk_ret_d = S_RM1;
          state_d  = S_LK_RD;
        end else begin
          head_d  = rm_n_q;
          state_d = S_RM1;
        end
      end
      S_RM1: begin
        if (!rm_n_q[bfpa_pkg::IDX_W]) begin
          lk_tgt_d = rm_n_q;
          lk_sel_d = LK_PREV;
          lk_val_d = rm_p_q;
          lk_ret_d = rm_ret_q;
          state_d  = S_LK_RD;
        end else begin
          tail_d  = rm_p_q;
          state_d = rm_ret_q;
        end
      end
      // Append app_idx at the tail.
      S_AP0: begin
        if (!tail_q[bfpa_pkg::IDX_W]) begin
          lk_tgt_d = tail_q;
          lk_sel_d = LK_NEXT;
          lk_val_d = {1'b0, app_idx_q};
          lk_ret_d = S_AP1;
          state_d  = S_LK_RD;
        end else begin
          head_d  = {1'b0, app_idx_q};
          state_d = S_AP1;
        end
      end
      S_AP1: begin
        we        = 1'b1;
        waddr     = app_idx_q;
        wdata     = app_rec_q;
        wdata.prv = tail_q;
        wdata.nxt = bfpa_pkg::LINK_NIL;
        tail_d    = {1'b0, app_idx_q};
        state_d   = S_DONE;
      end
      S_LK_RD: begin
        re      = 1'b1;
        raddr   = lk_tgt_q[bfpa_pkg::IDX_W-1:0];
        state_d = S_LK_WR;
      end
      S_LK_WR: begin
        r = rd_rec;
        if (lk_sel_q == LK_NEXT) begin
          r.nxt = lk_val_q;
        end else begin
          r.prv = lk_val_q;
        end
        we      = 1'b1;
        waddr   = lk_tgt_q[bfpa_pkg::IDX_W-1:0];
        wdata   = r;
        state_d = lk_ret_q;
      end
      S_DONE: begin
        if (!out_valid_q || out_acc) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_addr_d = re ? raddr : rd_addr_q;
    e0_init_d = e0_init_q && !(we && waddr == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rm_ret_q    <= S_IDLE;
      lk_ret_q    <= S_IDLE;
      lk_sel_q    <= LK_NEXT;
      valid_q     <= {{(bfpa_pkg::MAX_BLOCKS-1){1'b0}}, 1'b1};
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
      e0_init_q   <= 1'b1;
      rd_addr_q   <= '0;
    end else begin
      state_q     <= state_d;
      rm_ret_q    <= rm_ret_d;
      lk_ret_q    <= lk_ret_d;
      lk_sel_q    <= lk_sel_d;
      valid_q     <= valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      e0_init_q   <= e0_init_d;
      rd_addr_q   <= rd_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rm_p_q     <= rm_p_d;
    rm_n_q     <= rm_n_d;
    lk_tgt_q   <= lk_tgt_d;
    lk_val_q   <= lk_val_d;
    best_q     <= best_d;
    best_rec_q <= best_rec_d;
    cur_rec_q  <= cur_rec_d;
    app_rec_q  <= app_rec_d;
    ix_q       <= ix_d;
    cur_q      <= cur_d;
    app_idx_q  <= app_idx_d;
    req_q      <= req_d;
    addr_q     <= addr_d;
    tgt_q      <= tgt_d;
    res_off_q  <= res_off_d;
    res_st_q   <= res_st_d;
    out_off_q  <= out_off_d;
    out_st_q   <= out_st_d;
  end

  // Between requests the free list is empty at both ends or at neither.
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> head_q[bfpa_pkg::IDX_W] == tail_q[bfpa_pkg::IDX_W])
    else $error("free list head/tail disagree");

  // Never read and write the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(re && we && raddr == waddr))
    else $error("RAM read/write collision");

  // No table writes while idle.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we)
    else $error("RAM write while idle");

  // Entry 0 override only goes away.
  a_e0_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(e0_init_q))
    else $error("entry 0 reset override came back");

  // A result is only presented out of the done state.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result without completion");

endmodule

/* tb/tb_best_fit_pool_allocator_unit.sv */
// Self-checking testbench for the best-fit pool allocator unit.
module tb_best_fit_pool_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NONE     = -1;
  localparam int N_RANDOM = 1300;

  // Expected response beat, oldest first.
  typedef struct {
    logic [bfpa_pkg::ADDR_W-1:0] offset;
    logic [bfpa_pkg::STAT_W-1:0] status;
  } rsp_beat_t;

  logic clk_i;
  logic rst_ni;

  bfpa_req_if req_bus ();
  bfpa_rsp_if rsp_bus ();

  best_fit_pool_allocator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block table and free list.
  // ---------------------------------------------------------------------------
  int unsigned blk_start [bfpa_pkg::MAX_BLOCKS];
  int unsigned blk_size  [bfpa_pkg::MAX_BLOCKS];
  bit          blk_taken [bfpa_pkg::MAX_BLOCKS];   // allocated
  bit          blk_used  [bfpa_pkg::MAX_BLOCKS];   // table entry in use
  int          fl_next   [bfpa_pkg::MAX_BLOCKS];
  int          fl_prev   [bfpa_pkg::MAX_BLOCKS];
  int          fl_head;
  int          fl_tail;

  rsp_beat_t   pending_rsp [$];   // responses still owed by the block
  int unsigned live_offs   [$];   // payload offsets currently allocated
  int          errors;
  bit          rsp_stall_on;

  function automatic void pool_reset();
    for (int i = 0; i < bfpa_pkg::MAX_BLOCKS; i++) begin
      blk_start[i] = 0;
      blk_size[i]  = 0;
      blk_taken[i] = 1'b0;
      blk_used[i]  = 1'b0;
      fl_next[i]   = NONE;
      fl_prev[i]   = NONE;
    end
    blk_used[0] = 1'b1;
    blk_size[0] = bfpa_pkg::POOL_BYTES - bfpa_pkg::TAG2;
    fl_head     = 0;
    fl_tail     = 0;
  endfunction

  function automatic void fl_unlink(int i);
    int p;
    int n;
    p = fl_prev[i];
    n = fl_next[i];
    if (p != NONE) fl_next[p] = n;
    else fl_head = n;
    if (n != NONE) fl_prev[n] = p;
    else fl_tail = p;
    fl_prev[i] = NONE;
    fl_next[i] = NONE;
  endfunction

  function automatic void fl_push_tail(int i);
    fl_prev[i] = fl_tail;
    fl_next[i] = NONE;
    if (fl_tail != NONE) fl_next[fl_tail] = i;
    else fl_head = i;
    fl_tail = i;
  endfunction

  function automatic int entry_at(int unsigned start);
    for (int i = 0; i < bfpa_pkg::MAX_BLOCKS; i++)
      if (blk_used[i] && blk_start[i] == start) return i;
    return NONE;
  endfunction

  // Best fit: smallest adequate free block, earliest in list order on ties.
  function automatic rsp_beat_t best_fit_alloc(int unsigned req);
    rsp_beat_t r;
    int        cur;
    int        best;
    int        steps;
    int        spare;
    int unsigned sz;
    cur   = fl_head;
    best  = NONE;
    steps = 0;
    while (cur != NONE && steps < bfpa_pkg::MAX_BLOCKS) begin
      if (blk_size[cur] >= req && (best == NONE || blk_size[cur] < blk_size[best]))
        best = cur;
      cur = fl_next[cur];
      steps++;
    end
    r.offset = '0;
    if (best == NONE) begin
      r.status = bfpa_pkg::ST_NOFIT;
      return r;
    end
    fl_unlink(best);
    blk_taken[best] = 1'b1;
    sz = blk_size[best];
    if (sz > req + bfpa_pkg::SPLIT_SLACK && sz > req + bfpa_pkg::TAG2) begin
      spare = NONE;
      for (int i = 0; i < bfpa_pkg::MAX_BLOCKS; i++)
        if (!blk_used[i] && spare == NONE) spare = i;
      // Table full: block is handed out whole.
      if (spare != NONE) begin
        blk_size[best]   = req;
        blk_used[spare]  = 1'b1;
        blk_taken[spare] = 1'b0;
        blk_start[spare] = blk_start[best] + bfpa_pkg::TAG2 + req;
        blk_size[spare]  = sz - req - bfpa_pkg::TAG2;
        fl_push_tail(spare);
      end
    end
    r.offset = bfpa_pkg::ADDR_W'(blk_start[best] + bfpa_pkg::HEADER_BYTES);
    r.status = bfpa_pkg::ST_OK;
    live_offs.push_back(r.offset);
    return r;
  endfunction

  // Free with coalescing: next neighbor first, then previous neighbor.
  function automatic rsp_beat_t coalesce_free(logic [bfpa_pkg::ADDR_W-1:0] addr);
    rsp_beat_t r;
    int        cur;
    int        nb;
    int        pv;
    int        hits [$];
    r.offset = '0;
    cur = NONE;
    for (int i = 0; i < bfpa_pkg::MAX_BLOCKS; i++)
      if (cur == NONE && blk_used[i] &&
          bfpa_pkg::ADDR_W'(blk_start[i] + bfpa_pkg::HEADER_BYTES) == addr)
        cur = i;
    // Unknown address or double free.
    if (cur == NONE || !blk_taken[cur]) begin
      r.status = bfpa_pkg::ST_FREED;
      return r;
    end
    blk_taken[cur] = 1'b0;
    hits = live_offs.find_first_index(x) with (x == addr);
    if (hits.size() > 0) live_offs.delete(hits[0]);
    nb = entry_at(blk_start[cur] + blk_size[cur] + bfpa_pkg::TAG2);
    if (nb != NONE && !blk_taken[nb]) begin
      blk_size[cur] += blk_size[nb] + bfpa_pkg::TAG2;
      fl_unlink(nb);
      blk_used[nb] = 1'b0;
    end
    pv = NONE;
    for (int i = 0; i < bfpa_pkg::MAX_BLOCKS; i++)
      if (pv == NONE && blk_used[i] && i != cur && !blk_taken[i] &&
          blk_start[i] + blk_size[i] + bfpa_pkg::TAG2 == blk_start[cur])
        pv = i;
    if (pv != NONE) begin
      blk_size[pv] += blk_size[cur] + bfpa_pkg::TAG2;
      fl_unlink(pv);
      blk_used[cur] = 1'b0;
      fl_next[cur]  = NONE;
      fl_prev[cur]  = NONE;
      cur = pv;
    end
    fl_push_tail(cur);
    r.status = bfpa_pkg::ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Gaps: mostly short, a few long, with no-gap stretches.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Send one request beat; prediction happens at the accepting edge.
  int burst_left;
  task automatic send_beat(logic kind, logic [bfpa_pkg::ADDR_W-1:0] size,
                           logic [bfpa_pkg::ADDR_W-1:0] addr);
    int g;
    @(negedge clk_i);
    req_bus.valid         = 1'b1;
    req_bus.kind          = kind;
    req_bus.request_size  = size;
    req_bus.block_address = addr;
    do @(posedge clk_i); while (!req_bus.ready);
    if (kind == bfpa_pkg::KIND_ALLOC) pending_rsp.push_back(best_fit_alloc(size));
    else pending_rsp.push_back(coalesce_free(addr));
    if (burst_left > 0) begin
      burst_left--;
      g = 0;
    end else begin
      g = gap_len();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
    end
    if (g > 0) begin
      @(negedge clk_i);
      req_bus.valid = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Drop the request line, then wait for every owed response.
  task automatic wait_drained();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Response-side back pressure, driven at the falling edge.
  initial begin
    int hold;
    rsp_bus.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!rsp_stall_on || $urandom_range(0, 3) != 0) begin
        rsp_bus.ready = 1'b1;
        if (rsp_stall_on && $urandom_range(0, 4) == 0) hold = gap_len();
      end else begin
        rsp_bus.ready = 1'b0;
        hold = gap_len();
      end
    end
  end

  // Response checker: each beat against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_beat_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat, status", rsp_bus.status, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch("status", rsp_bus.status, want.status);
        if (rsp_bus.payload_offset !== want.offset)
          report_mismatch("payload_offset", rsp_bus.payload_offset, want.offset);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic free_everything();
    while (live_offs.size() != 0)
      send_beat(bfpa_pkg::KIND_FREE, 12'($urandom),
                live_offs[$urandom_range(0, live_offs.size() - 1)]);
  endtask

  // Field extremes, zero request, no fit, double free, unknown addresses.
  task automatic test_directed_edges();
    logic [bfpa_pkg::ADDR_W-1:0] first;
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd0, 12'hFFF);
    first = live_offs[0];
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd1, 12'd0);
    send_beat(bfpa_pkg::KIND_ALLOC, 12'hFFF, 12'hABC);   // never fits
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd4048, 12'd0);    // too big once the pool is split
    send_beat(bfpa_pkg::KIND_FREE, 12'hFFF, first);
    send_beat(bfpa_pkg::KIND_FREE, 12'h000, first);      // double free
    send_beat(bfpa_pkg::KIND_FREE, 12'd5, 12'hFFF);      // unknown address
    send_beat(bfpa_pkg::KIND_FREE, 12'd5, 12'h000);
    send_beat(bfpa_pkg::KIND_FREE, 12'd5, 12'h555);
    free_everything();
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd4048, 12'h2AA);  // whole pool
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd0, 12'd0);       // nothing left
    free_everything();
  endtask

  // Split threshold: slack bound and tag bound.
  task automatic test_split_limits();
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd3948, 12'd0);    // exactly req + slack: whole
    free_everything();
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd3947, 12'd0);    // one past: split
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd1, 12'd0);       // takes the 53-byte remainder whole
    free_everything();
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd200, 12'd0);
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd300, 12'd0);
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd200, 12'd0);
    send_beat(bfpa_pkg::KIND_FREE, 12'd0, live_offs[1]); // hole of 300 between two blocks
    send_beat(bfpa_pkg::KIND_ALLOC, 12'd250, 12'd0);     // best fit takes the hole
    free_everything();
  endtask

  // Mostly legal alloc/free traffic, some noise.
  task automatic test_random_traffic(int count);
    int roll;
    logic [bfpa_pkg::ADDR_W-1:0] sz;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 52 || live_offs.size() == 0) begin
        case ($urandom_range(0, 9))
          0:       sz = 12'($urandom);
          1, 2:    sz = 12'($urandom_range(0, 1200));
          default: sz = 12'($urandom_range(0, 160));
        endcase
        send_beat(bfpa_pkg::KIND_ALLOC, sz, 12'($urandom));
      end else if (roll < 93) begin
        send_beat(bfpa_pkg::KIND_FREE, 12'($urandom),
                  live_offs[$urandom_range(0, live_offs.size() - 1)]);
      end else begin
        send_beat(bfpa_pkg::KIND_FREE, 12'($urandom), 12'($urandom));
      end
    end
  endtask

  // Sender holds off until every response has come back.
  task automatic test_drain_pause();
    test_random_traffic(30);
    wait_drained();
    test_random_traffic(30);
  endtask

  initial begin
    errors        = 0;
    burst_left    = 0;
    rsp_stall_on  = 1'b1;
    rst_ni        = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.kind          = bfpa_pkg::KIND_ALLOC;
    req_bus.request_size  = '0;
    req_bus.block_address = '0;
    pool_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_split_limits();
    test_drain_pause();
    test_random_traffic(N_RANDOM / 2);
    rsp_stall_on = 1'b0;                // stretch without response stalls
    test_random_traffic(N_RANDOM / 4);
    rsp_stall_on = 1'b1;
    test_random_traffic(N_RANDOM / 4);
    free_everything();

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("tb_best_fit_pool_allocator_unit: PASS");
    end else begin
      $display("tb_best_fit_pool_allocator_unit: FAIL");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished in time.
  initial begin
    #60_000_000;
    $display("tb_best_fit_pool_allocator_unit: FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/bfpa_pkg.sv
src/bfpa_if.sv
src/bfpa_ram.sv
src/best_fit_pool_allocator_unit.sv
tb/tb_best_fit_pool_allocator_unit.sv
